>>> design/avs_pkg.sv
// Shared constants, types and codes of the audio-master lip-sync regulator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package avs_pkg;

  // Width of every time value (microseconds).
  localparam int TIME_BITS     = 48;
  // Signed width for differences of time values, with guard bits.
  localparam int DIFF_BITS     = TIME_BITS + 4;
  localparam int IDX_BITS      = 32;
  localparam int INTERVAL_BITS = 20;
  localparam int NOSYNC_BITS   = 27;
  localparam int THR_BITS      = 20;
  localparam int RUN_BITS      = 4;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 27;
  // Frame index times interval.
  localparam int PROD_BITS     = IDX_BITS + INTERVAL_BITS;
  // Signed width of the fixed-rate target and wait time.
  localparam int TGT_BITS      = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 3;

  localparam int ONE_SEC    = 1000000;
  localparam int DIFF_CAP   = 200000;
  localparam int NUDGE_MIN  = 20000;
  localparam int NUDGE_CAP  = 50000;
  localparam int NUDGE_FULL = 2 * NUDGE_CAP;
  localparam int NUDGE_BITS = 18;
  localparam int RUN_LIMIT  = 10;

  localparam int INTERVAL_RST = 33333;
  localparam int NOSYNC_RST   = 10000000;
  localparam int MIN_THR_RST  = 40000;
  localparam int MAX_THR_RST  = 100000;

  typedef logic        [TIME_BITS-1:0] time_t;
  typedef logic signed [TIME_BITS-1:0] stime_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_AUDIO        = 2'd0,
    MODE_VIDEO        = 2'd1,
    MODE_DROP_QUERY   = 2'd2,
    MODE_TIMING_RESET = 2'd3
  } avs_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIXED_RATE = 3'd0,
    CFG_INTERVAL   = 3'd1,
    CFG_NOSYNC     = 3'd2,
    CFG_MIN_THR    = 3'd3,
    CFG_MAX_THR    = 3'd4
  } avs_cfg_idx_e;

  typedef struct packed {
    logic                     fixed_rate;
    logic [INTERVAL_BITS-1:0] interval;
    logic [NOSYNC_BITS-1:0]   nosync;
    logic [THR_BITS-1:0]      min_thr;
    logic [THR_BITS-1:0]      max_thr;
  } avs_cfg_t;

endpackage

`default_nettype wire

>>> design/avs_if.sv
// Valid/ready channel interfaces of the lip-sync regulator: requests,
// results and register writes. Depends on avs_pkg.
`default_nettype none

interface avs_item_if import avs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  stime_t               pts_us;
  time_t                now_us;

  modport source (output valid, mode, pts_us, now_us, input ready);
  modport sink   (input valid, mode, pts_us, now_us, output ready);
endinterface

interface avs_result_if import avs_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t delay_us;
  logic  drop_frame;

  modport source (output valid, delay_us, drop_frame, input ready);
  modport sink   (input valid, delay_us, drop_frame, output ready);
endinterface

interface avs_cfg_if import avs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/avs_cfg.sv
// Configuration register file of the lip-sync regulator.
// Depends on avs_pkg and avs_cfg_if.
`default_nettype none

module avs_cfg import avs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  avs_cfg_if.sink   cfg_i,
  output avs_cfg_t  cfg_o,
  output logic      restart_o
);

  avs_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Writing the mode register restarts frame counting.
  assign restart_o = cfg_i.valid && (cfg_i.index == CFG_FIXED_RATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_rate <= 1'b0;
      cfg_q.interval   <= INTERVAL_BITS'(INTERVAL_RST);
      cfg_q.nosync     <= NOSYNC_BITS'(NOSYNC_RST);
      cfg_q.min_thr    <= THR_BITS'(MIN_THR_RST);
      cfg_q.max_thr    <= THR_BITS'(MAX_THR_RST);
    end else if (cfg_i.valid) begin
      unique case (avs_cfg_idx_e'(cfg_i.index))
        CFG_FIXED_RATE: cfg_q.fixed_rate <= cfg_i.data[0];
        CFG_INTERVAL:   cfg_q.interval   <= cfg_i.data[INTERVAL_BITS-1:0];
        CFG_NOSYNC:     cfg_q.nosync     <= cfg_i.data[NOSYNC_BITS-1:0];
        CFG_MIN_THR:    cfg_q.min_thr    <= cfg_i.data[THR_BITS-1:0];
        CFG_MAX_THR:    cfg_q.max_thr    <= cfg_i.data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/avs_engine.sv
// Timing state and per-request arithmetic of the lip-sync regulator.
// Depends on avs_pkg.
`default_nettype none

module avs_engine import avs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 restart_i,
  input  wire avs_cfg_t             cfg_i,
  input  wire logic [MODE_BITS-1:0] mode_i,
  input  wire stime_t               pts_i,
  input  wire time_t                now_i,
  output time_t                     delay_o,
  output logic                      drop_o
);

  stime_t                apts_q;
  time_t                 stamp_q;
  stime_t                last_vpts_q;
  time_t                 last_delay_q;
  time_t                 pstart_q;
  logic [IDX_BITS-1:0]   idx_q;
  logic                  started_q;
  logic [RUN_BITS-1:0]   run_q;
  logic                  drop_q;

  avs_mode_e                    mode;
  logic signed [DIFF_BITS-1:0]  aclk, diff, base_raw, base, hi_s, lo_s, thr_min, thr;
  logic        [DIFF_BITS-1:0]  mag;
  logic                         in_range, base_bad, fire;
  time_t                        delay_diff, delay_fix, start;
  logic        [RUN_BITS-1:0]   run_next;
  logic                         drop_set;
  logic        [PROD_BITS-1:0]  prod;
  logic        [NUDGE_BITS-1:0] nudge_mag;
  logic signed [TGT_BITS-1:0]   nudge, wait_t;

  assign mode = avs_mode_e'(mode_i);

  // Audio clock and the video lead over it.
  always_comb begin
    aclk = DIFF_BITS'(apts_q) + (DIFF_BITS'(now_i) - DIFF_BITS'(stamp_q));
    diff = DIFF_BITS'(pts_i) - aclk;
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    in_range = mag < DIFF_BITS'(cfg_i.nosync);
  end

  // Differential mode: threshold from the frame spacing, clamped.
  always_comb begin
    base_raw = DIFF_BITS'(pts_i) - DIFF_BITS'(last_vpts_q);
    base_bad = (base_raw <= 0) || (base_raw >= ONE_SEC);
    base     = base_bad ? signed'(DIFF_BITS'(last_delay_q)) : base_raw;
    hi_s     = signed'(DIFF_BITS'(cfg_i.max_thr));
    lo_s     = signed'(DIFF_BITS'(cfg_i.min_thr));
    thr_min  = (base < hi_s) ? base : hi_s;
    thr      = (thr_min < lo_s) ? lo_s : thr_min;
    fire     = (diff >= thr) && (diff > 0);
    if (in_range && fire) begin
      delay_diff = (diff >= DIFF_CAP) ? TIME_BITS'(DIFF_CAP) : TIME_BITS'(diff);
    end else begin
      delay_diff = '0;
    end
    if (delay_diff != '0) begin
      run_next = '0;
    end else if (run_q == '1) begin
      run_next = run_q;
    end else begin
      run_next = run_q + RUN_BITS'(1);
    end
    drop_set = in_range && (diff < -ONE_SEC) && (run_next >= RUN_BITS'(RUN_LIMIT));
  end

  // Fixed-rate mode: scheduled target nudged towards the audio clock.
  always_comb begin
    start = started_q ? pstart_q : now_i;
    prod  = PROD_BITS'(idx_q) * PROD_BITS'(cfg_i.interval);
    // Half the lead, rounded towards zero, capped in magnitude.
    nudge_mag = (mag >= DIFF_BITS'(NUDGE_FULL)) ? NUDGE_BITS'(NUDGE_CAP)
                                                : NUDGE_BITS'(mag[DIFF_BITS-1:1]);
    if (in_range && (mag > DIFF_BITS'(NUDGE_MIN))) begin
      nudge = diff[DIFF_BITS-1] ? -signed'(TGT_BITS'(nudge_mag))
                                : signed'(TGT_BITS'(nudge_mag));
    end else begin
      nudge = '0;
    end
    wait_t = signed'(TGT_BITS'(start)) + signed'(TGT_BITS'(prod)) + nudge
             - signed'(TGT_BITS'(now_i));
    if (wait_t <= 0) begin
      delay_fix = '0;
    end else if (|wait_t[TGT_BITS-1:TIME_BITS]) begin
      delay_fix = '1;
    end else begin
      delay_fix = wait_t[TIME_BITS-1:0];
    end
  end

  always_comb begin
    delay_o = '0;
    drop_o  = 1'b0;
    unique case (mode)
      MODE_VIDEO:      delay_o = cfg_i.fixed_rate ? delay_fix : delay_diff;
      MODE_DROP_QUERY: drop_o  = drop_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apts_q       <= '0;
      stamp_q      <= '0;
      last_vpts_q  <= '0;
      last_delay_q <= '0;
      pstart_q     <= '0;
      idx_q        <= '0;
      started_q    <= 1'b0;
      run_q        <= '0;
      drop_q       <= 1'b0;
    end else if (restart_i) begin
      idx_q     <= '0;
      started_q <= 1'b0;
    end else if (step_i) begin
      unique case (mode)
        MODE_AUDIO: begin
          apts_q  <= pts_i;
          stamp_q <= now_i;
        end
        MODE_VIDEO: begin
          last_vpts_q <= pts_i;
          if (cfg_i.fixed_rate) begin
            last_delay_q <= delay_fix;
            idx_q        <= idx_q + IDX_BITS'(1);
            if (!started_q) begin
              started_q <= 1'b1;
              pstart_q  <= now_i;
            end
          end else begin
            last_delay_q <= delay_diff;
            if (in_range) begin
              run_q <= run_next;
              if (drop_set) begin
                drop_q <= 1'b1;
              end
            end
          end
        end
        MODE_DROP_QUERY: drop_q <= 1'b0;
        MODE_TIMING_RESET: begin
          last_vpts_q  <= '0;
          last_delay_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/av_sync_video_delay.sv
// Top level of the audio-master lip-sync regulator: request register,
// result register and handshakes. Depends on avs_pkg, avs_if, avs_cfg and avs_engine.
`default_nettype none

// The block keeps video in step with an audio master clock. Each request
// transfer carries a mode: an audio update latches the audio presentation time
// together with the time now; a video frame works out the audio clock from
// those, compares the frame's timestamp against it and returns the wait time
// in microseconds, either as the lead above a clamped threshold (differential
// mode, at most 200 ms, with a sticky drop flag raised by long runs of zero
// delays while video trails by more than a second) or as a fixed-rate schedule
// nudged towards the audio clock; a drop query returns and clears the drop
// flag; a timing reset forgets the last frame. Every request yields exactly one
// result transfer. The block takes one request per clock cycle while the result
// is not stalled: a request is captured in an input register, the whole
// computation (including the 32 by 20 bit frame schedule multiply) is done by
// the logic between that register and the result register, and the timing
// state is written back at the same edge, so back-to-back requests see each
// other's effects. A stalled result holds in the result register while the
// next request waits in the input register. There is no clearing pass after
// reset. Registers are written through the
// configuration channel, which is always ready; they must only be written while
// no request is in flight, and a write of the mode register restarts frame
// counting.
module av_sync_video_delay import avs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  avs_item_if.sink     item_i,
  avs_result_if.source result_o,
  avs_cfg_if.sink      cfg_i
);

  avs_cfg_t             cfg;
  logic                 restart;

  logic                 in_valid_q;
  logic [MODE_BITS-1:0] in_mode_q;
  stime_t               in_pts_q;
  time_t                in_now_q;

  logic                 out_valid_q;
  time_t                out_delay_q;
  logic                 out_drop_q;

  logic                 advance;
  logic                 step;
  time_t                eng_delay;
  logic                 eng_drop;

  // The result register can take a new value when it is empty or its
  // contents leave in this cycle; the input register follows the same way.
  assign advance      = !out_valid_q || result_o.ready;
  assign item_i.ready = !in_valid_q || advance;
  assign step         = in_valid_q && advance;

  avs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  avs_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (restart),
    .cfg_i     (cfg),
    .mode_i    (in_mode_q),
    .pts_i     (in_pts_q),
    .now_i     (in_now_q),
    .delay_o   (eng_delay),
    .drop_o    (eng_drop)
  );

  // Input register: control cleared at reset, payload loaded on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_mode_q <= item_i.mode;
      in_pts_q  <= item_i.pts_us;
      in_now_q  <= item_i.now_us;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_delay_q <= eng_delay;
      out_drop_q  <= eng_drop;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.delay_us   = out_delay_q;
  assign result_o.drop_frame = out_drop_q;

  // A request held back by a stalled result keeps its place and contents.
  a_hold_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_pts_q) && $stable(in_now_q))
    else $error("held request lost or changed");

  // The differential wait never exceeds its 200 ms cap.
  a_diff_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_mode_q == MODE_VIDEO) && !cfg.fixed_rate
      |-> eng_delay <= TIME_BITS'(DIFF_CAP))
    else $error("differential delay above cap");

  // Audio updates and timing resets give an empty result.
  a_quiet_modes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && ((in_mode_q == MODE_AUDIO) || (in_mode_q == MODE_TIMING_RESET))
      |=> (out_delay_q == '0) && !out_drop_q)
    else $error("non-empty result for a non-video request");

endmodule

`default_nettype wire

>>> tb/sv/tb_av_sync_video_delay.sv
`timescale 1ns / 1ps
// Self-checking testbench of the audio-master lip-sync regulator.
// Depends on avs_pkg, the avs_if channel interfaces and av_sync_video_delay.

module tb_av_sync_video_delay;
  import avs_pkg::*;

  // Once no transfer has happened for this many cycles, the run is declared hung.
  localparam int     IDLE_LIMIT    = 2000;
  // A request passes the input and the result register before its result. These pauses leave margin.
  localparam int     SETTLE_CYCLES = 4;
  localparam int     END_CYCLES    = 10;
  localparam int     MAX_REPORTS   = 10;
  localparam longint TIME_MAX      = (longint'(1) << TIME_BITS) - 1;
  localparam stime_t PTS_MAX       = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam stime_t PTS_MIN       = {1'b1, {(TIME_BITS-1){1'b0}}};

  // Expected result of one request.
  typedef struct {
    time_t delay_us;
    logic  drop_frame;
  } frame_answer_t;

  // The scoreboard keeps a private copy of the registers and the timing state.
  // Each accepted request advances that copy and queues the answer the block
  // owes. Each result transfer is then compared with the oldest queued answer.
  class avsync_scoreboard;
    avs_cfg_t             regs;
    stime_t               master_pts;
    time_t                audio_stamp;
    stime_t               prev_frame_pts;
    time_t                last_wait;
    time_t                sched_start;
    logic [IDX_BITS-1:0]  frame_count;
    logic                 sched_started;
    logic [RUN_BITS-1:0]  zero_run;
    logic                 drop_flag;
    frame_answer_t        pending_answers[$];
    int                   faults;
    int                   requests;
    int                   frames;
    int                   drops_seen;

    function new();
      regs.fixed_rate = 1'b0;
      regs.interval   = INTERVAL_BITS'(INTERVAL_RST);
      regs.nosync     = NOSYNC_BITS'(NOSYNC_RST);
      regs.min_thr    = THR_BITS'(MIN_THR_RST);
      regs.max_thr    = THR_BITS'(MAX_THR_RST);
      master_pts      = '0;
      audio_stamp     = '0;
      prev_frame_pts  = '0;
      last_wait       = '0;
      sched_start     = '0;
      frame_count     = '0;
      sched_started   = 1'b0;
      zero_run        = '0;
      drop_flag       = 1'b0;
      faults          = 0;
      requests        = 0;
      frames          = 0;
      drops_seen      = 0;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    function void apply_write(logic [CFG_IDX_BITS-1:0] idx,
                              logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_FIXED_RATE: begin
          regs.fixed_rate = value[0];
          frame_count     = '0;
          sched_started   = 1'b0;
        end
        CFG_INTERVAL: regs.interval = value[INTERVAL_BITS-1:0];
        CFG_NOSYNC:   regs.nosync   = value[NOSYNC_BITS-1:0];
        CFG_MIN_THR:  regs.min_thr  = value[THR_BITS-1:0];
        CFG_MAX_THR:  regs.max_thr  = value[THR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(avs_mode_e m, stime_t pts, time_t now);
      longint          aclk;
      longint          diff;
      longint          base;
      longint          thr;
      longint          tgt;
      longint          wait_t;
      longint          half_d;
      longint unsigned mag;
      logic            in_sync;
      frame_answer_t   ans;
      ans.delay_us   = '0;
      ans.drop_frame = 1'b0;
      requests++;
      case (m)
        MODE_AUDIO: begin
          master_pts  = pts;
          audio_stamp = now;
        end
        MODE_VIDEO: begin
          frames++;
          // All arithmetic is done on 64 bits, so nothing wraps within the field ranges.
          aclk    = longint'(master_pts) + (longint'(now) - longint'(audio_stamp));
          diff    = longint'(pts) - aclk;
          mag     = (diff < 0) ? -diff : diff;
          in_sync = mag < longint'(regs.nosync);
          if (regs.fixed_rate) begin
            if (!sched_started) begin
              sched_started = 1'b1;
              sched_start   = now;
            end
            tgt = longint'(sched_start) + longint'(frame_count) * longint'(regs.interval);
            frame_count++;
            if (in_sync) begin
              // Signed division truncates, which is the halving towards zero.
              half_d = diff / 2;
              if (diff > NUDGE_MIN)
                tgt += (half_d < NUDGE_CAP) ? half_d : longint'(NUDGE_CAP);
              else if (diff < -NUDGE_MIN)
                tgt += (half_d > -NUDGE_CAP) ? half_d : -longint'(NUDGE_CAP);
            end
            wait_t = tgt - longint'(now);
            if (wait_t > 0)
              ans.delay_us = (wait_t > TIME_MAX) ? '1 : time_t'(wait_t);
          end else begin
            base = longint'(pts) - longint'(prev_frame_pts);
            if (base <= 0 || base >= ONE_SEC)
              base = longint'(last_wait);
            if (in_sync) begin
              thr = (base < longint'(regs.max_thr)) ? base : longint'(regs.max_thr);
              if (thr < longint'(regs.min_thr))
                thr = longint'(regs.min_thr);
              if (diff > -thr && diff >= thr)
                ans.delay_us = (diff < DIFF_CAP) ? time_t'(diff) : time_t'(DIFF_CAP);
              if (ans.delay_us == '0) begin
                if (zero_run != '1)
                  zero_run++;
              end else begin
                zero_run = '0;
              end
              if (diff < -ONE_SEC && zero_run >= RUN_LIMIT)
                drop_flag = 1'b1;
            end
          end
          last_wait      = ans.delay_us;
          prev_frame_pts = pts;
        end
        MODE_DROP_QUERY: begin
          ans.drop_frame = drop_flag;
          drop_flag      = 1'b0;
          if (ans.drop_frame)
            drops_seen++;
        end
        default: begin
          prev_frame_pts = '0;
          last_wait      = '0;
        end
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void note_mismatch(string what);
      faults++;
      if (faults <= MAX_REPORTS)
        $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void check_answer(time_t delay, logic drop);
      frame_answer_t want;
      if (pending_answers.size() == 0) begin
        note_mismatch($sformatf("result with no request outstanding (delay %0d, drop %0b)",
                                delay, drop));
        return;
      end
      want = pending_answers.pop_front();
      if (delay !== want.delay_us)
        note_mismatch($sformatf("delay_us expected %0d, got %0d", want.delay_us, delay));
      if (drop !== want.drop_frame)
        note_mismatch($sformatf("drop_frame expected %0b, got %0b", want.drop_frame, drop));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  avs_item_if   item_bus ();
  avs_result_if result_bus ();
  avs_cfg_if    cfg_bus ();

  av_sync_video_delay DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  avsync_scoreboard sb;

  // Steady stretches switch the random gaps off on one side for a while.
  bit     src_steady = 1'b0;
  bit     snk_steady = 1'b0;
  int     idle_cycles = 0;
  int     setting_count = 0;

  // State of the stimulus generator: a wall clock, the offset of the media
  // timeline from it, what the block last heard from audio, and any burst of
  // lagging video frames still to be sent.
  longint wall;
  longint media_off;
  longint gen_master_pts;
  longint gen_audio_now;
  longint lag_off;
  int     lag_left;

  always #1 clk_i = ~clk_i;

  // Gaps are mostly absent or short, with the odd long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one request after an optional gap and hold it until its transfer.
  // On return the task sits on a falling edge with valid still high, so that a
  // following request can go out back to back.
  task automatic drive_item(avs_mode_e m, stime_t pts, time_t now);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid  <= 1'b1;
    item_bus.mode   <= m;
    item_bus.pts_us <= pts;
    item_bus.now_us <= now;
    do @(posedge clk_i); while (!item_bus.ready);
    sb.note_request(m, pts, now);
    @(negedge clk_i);
  endtask

  // Valid drops between register writes so that it never falls and rises
  // again on the same edge.
  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.apply_write(idx, value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [CFG_DATA_BITS-1:0] fixed_rate,
                                logic [CFG_DATA_BITS-1:0] interval,
                                logic [CFG_DATA_BITS-1:0] nosync,
                                logic [CFG_DATA_BITS-1:0] min_thr,
                                logic [CFG_DATA_BITS-1:0] max_thr);
    setting_count++;
    cfg_write(CFG_INTERVAL, interval);
    cfg_write(CFG_NOSYNC, nosync);
    cfg_write(CFG_MIN_THR, min_thr);
    cfg_write(CFG_MAX_THR, max_thr);
    cfg_write(CFG_FIXED_RATE, fixed_rate);
  endtask

  // Stop offering requests and wait until every answer has come back, then pause
  // further so that the block is entirely quiet before any register write.
  task automatic drain_requests();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Random traffic. Most requests follow a plausible playback: time moves
  // forward, audio updates track the media timeline, and video frames sit near
  // the audio clock, well away from it, beyond the no-sync range, or in runs that
  // trail it by more than a second so that the drop flag gets raised. A small
  // share is pure noise over the whole field ranges.
  task automatic run_traffic(int count);
    longint    pts_v;
    longint    now_v;
    longint    aclk_v;
    longint    off;
    avs_mode_e m;
    int        pick;
    int        sel;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0)
        src_steady = !src_steady;
      wall  += $urandom_range(0, 25000);
      aclk_v = gen_master_pts + (wall - gen_audio_now);
      pick   = $urandom_range(0, 99);
      if (pick < 8) begin
        m     = avs_mode_e'($urandom_range(0, 3));
        pts_v = {$urandom, $urandom};
        now_v = {$urandom, $urandom};
      end else if (pick < 38) begin
        m     = MODE_AUDIO;
        pts_v = wall + media_off + longint'($urandom_range(0, 4000)) - 2000;
        now_v = wall;
      end else if (pick < 86) begin
        m     = MODE_VIDEO;
        now_v = wall;
        if (lag_left > 0) begin
          lag_left--;
          off = -lag_off;
        end else begin
          sel = $urandom_range(0, 19);
          if (sel < 10) begin
            off = longint'($urandom_range(0, 60000)) - 30000;
          end else if (sel < 14) begin
            off = longint'($urandom_range(0, 600000)) - 300000;
          end else if (sel < 16) begin
            off = longint'($urandom_range(0, 30000000)) - 15000000;
          end else begin
            lag_left = $urandom_range(10, 14);
            lag_off  = $urandom_range(1100000, 4000000);
            off      = -lag_off;
          end
        end
        pts_v = aclk_v + off;
      end else if (pick < 94) begin
        m     = MODE_DROP_QUERY;
        pts_v = {$urandom, $urandom};
        now_v = {$urandom, $urandom};
      end else begin
        m     = MODE_TIMING_RESET;
        pts_v = {$urandom, $urandom};
        now_v = {$urandom, $urandom};
      end
      if (m == MODE_AUDIO) begin
        gen_master_pts = longint'(stime_t'(pts_v));
        gen_audio_now  = longint'(time_t'(now_v));
      end
      drive_item(m, stime_t'(pts_v), time_t'(now_v));
    end
  endtask

  // The result side stalls at random, with its own steady stretches.
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0)
        snk_steady = !snk_steady;
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0)
          stall_left = pick_gap(snk_steady);
      end
    end
  end

  // Every result transfer is checked against the oldest outstanding answer.
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready)
      sb.check_answer(result_bus.delay_us, result_bus.drop_frame);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d answers outstanding",
               idle_cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    longint lag_now;
    rst_ni          = 1'b0;
    item_bus.valid  = 1'b0;
    item_bus.mode   = MODE_AUDIO;
    item_bus.pts_us = '0;
    item_bus.now_us = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_FIXED_RATE;
    cfg_bus.data    = '0;
    sb              = new();
    lag_left        = 0;
    lag_off         = 0;
    wall            = 5000000 + $urandom_range(0, 1000000);
    media_off       = longint'($urandom_range(0, 10000000)) - 5000000;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Differential mode with the reset register values. The drop flag starts clear.
    drive_item(MODE_DROP_QUERY, '0, '0);
    // Extreme audio stamp and time, then a frame at the opposite extremes: the
    // difference is far outside the no-sync range, so no wait is asked.
    drive_item(MODE_AUDIO, PTS_MIN, time_t'(TIME_MAX));
    drive_item(MODE_VIDEO, PTS_MAX, '0);
    drive_item(MODE_AUDIO, 1000000, 1000000);
    // Video 50 ms ahead: first with a base taken from the last delay, then with
    // a frame step below the lower clamp of the threshold.
    drive_item(MODE_VIDEO, 1050000, 1000000);
    drive_item(MODE_VIDEO, 1083333, 1033333);
    // Half a second ahead is capped at 200 ms.
    drive_item(MODE_VIDEO, 1566666, 1066666);
    // Twenty seconds ahead lies beyond the no-sync threshold.
    drive_item(MODE_VIDEO, 21100000, 1100000);
    // Ten frames two seconds behind build a run of zero delays that sets the flag.
    for (int i = 0; i < 10; i++) begin
      lag_now = 1200000 + i * 33333;
      drive_item(MODE_VIDEO, stime_t'(lag_now - 2000000), time_t'(lag_now));
    end
    // The flag is answered once and then cleared.
    drive_item(MODE_DROP_QUERY, PTS_MAX, time_t'(TIME_MAX));
    drive_item(MODE_DROP_QUERY, PTS_MIN, '0);
    drive_item(MODE_TIMING_RESET, PTS_MAX, time_t'(TIME_MAX));
    drain_requests();

    // Fixed-rate mode with the largest interval; all ones in the data word also
    // checks that the unused upper bits are dropped. Writes to indices past the
    // last register must change nothing.
    apply_settings(1, '1, CFG_DATA_BITS'(NOSYNC_RST), CFG_DATA_BITS'(MIN_THR_RST),
                   CFG_DATA_BITS'(MAX_THR_RST));
    for (int k = CFG_MAX_THR + 1; k < (1 << CFG_IDX_BITS); k++)
      cfg_write(CFG_IDX_BITS'(k), '1);
    drive_item(MODE_AUDIO, '0, '0);
    // The first frame latches the latest possible start; the next one, at time
    // zero, lands past the end of the time range and the wait saturates.
    drive_item(MODE_VIDEO, '0, time_t'(TIME_MAX));
    drive_item(MODE_VIDEO, '0, '0);
    drain_requests();

    // Fixed-rate mode with a zero interval: the target stays at the start time
    // and only the nudge towards the audio clock moves it.
    apply_settings(1, 0, CFG_DATA_BITS'(NOSYNC_RST), CFG_DATA_BITS'(MIN_THR_RST),
                   CFG_DATA_BITS'(MAX_THR_RST));
    drive_item(MODE_AUDIO, 1000000, 1000000);
    drive_item(MODE_VIDEO, 1060001, 1000000);
    drive_item(MODE_VIDEO, 1200000, 1000000);
    // Odd negative difference: halving rounds towards zero.
    drive_item(MODE_VIDEO, 839999, 900000);
    drive_item(MODE_VIDEO, 700000, 900000);
    // Exactly at the nudge boundary, where no nudge applies.
    drive_item(MODE_VIDEO, 920000, 900000);
    drain_requests();

    // The block's audio state as the directed part left it.
    gen_master_pts = 1000000;
    gen_audio_now  = 1000000;

    apply_settings(0, CFG_DATA_BITS'(INTERVAL_RST), CFG_DATA_BITS'(NOSYNC_RST),
                   CFG_DATA_BITS'(MIN_THR_RST), CFG_DATA_BITS'(MAX_THR_RST));
    run_traffic(120);
    drain_requests();

    apply_settings(1, 33333, 100000000, 0, 1000000);
    run_traffic(110);
    drain_requests();

    // Lower clamp above the upper one, widest no-sync range, smallest non-zero interval.
    apply_settings(0, 1, '1, 1000000, 0);
    run_traffic(110);
    drain_requests();

    apply_settings(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                   CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                   CFG_DATA_BITS'($urandom));
    run_traffic(110);
    drain_requests();

    repeat (END_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests, %0d of them video frames, and %0d raised drop flags,",
             sb.requests, sb.frames, sb.drops_seen);
    $display("over %0d register settings; %0d mismatches.", setting_count, sb.faults);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.faults == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
